// File: rtl/core/ucf_pkg.sv
// UTF-8 simple case fold: shared types, constants and fold functions.
// No dependencies.
`default_nettype none

package ucf_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD_E0  = 8'hE0;
	localparam logic [7:0] LEAD_ED  = 8'hED;
	localparam logic [7:0] LEAD_F0  = 8'hF0;
	localparam logic [7:0] LEAD_F4  = 8'hF4;

	localparam logic [20:0] CASE_OFS = 21'h20;
	localparam logic [20:0] CYR_OFS  = 21'h50;

	// one burst of result bytes caused by a single input item
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            fold;
		logic            eot;
	} burst_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] r;
		unique case (b) inside
			[LEAD2_LO:LEAD2_HI]: r = 3'd2;
			[8'hE0:8'hEF]:       r = 3'd3;
			[LEAD_F0:LEAD_F4]:   r = 3'd4;
			default:             r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic r;
		unique case (lead)
			LEAD_E0: r = (b >= 8'hA0) && (b <= 8'hBF);
			LEAD_ED: r = (b >= 8'h80) && (b <= 8'h9F);
			LEAD_F0: r = (b >= 8'h90) && (b <= 8'hBF);
			LEAD_F4: r = (b >= 8'h80) && (b <= 8'h8F);
			default: r = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic [20:0] fold_cp(input logic [20:0] cp);
		logic [20:0] r;
		r = cp;
		if (cp < 21'h80) begin
			if (cp >= 21'h41 && cp <= 21'h5A)
				r = cp + CASE_OFS;
		end else if ((cp >= 21'hC0 && cp <= 21'hD6) || (cp >= 21'hD8 && cp <= 21'hDE)) begin
			r = cp + CASE_OFS;
		end else if (cp >= 21'h100 && cp <= 21'h17F) begin
			if (cp == 21'h130 || cp == 21'h131 || cp == 21'h138 || cp == 21'h149 ||
			    cp == 21'h178) begin
				r = cp;
			end else if ((cp <= 21'h137) || (cp >= 21'h14A && cp <= 21'h177)) begin
				if (!cp[0])
					r = cp + 21'd1;
			end else if ((cp >= 21'h139 && cp <= 21'h148) ||
			             (cp >= 21'h179 && cp <= 21'h17E)) begin
				if (cp[0])
					r = cp + 21'd1;
			end
		end else if (cp >= 21'h391 && cp <= 21'h3A9 && cp != 21'h3A2) begin
			r = cp + CASE_OFS;
		end else if (cp >= 21'h410 && cp <= 21'h42F) begin
			r = cp + CASE_OFS;
		end else if (cp >= 21'h400 && cp <= 21'h40F) begin
			r = cp + CYR_OFS;
		end
		return r;
	endfunction

	// decode, fold and re-encode a complete sequence of cnt bytes
	function automatic burst_t fold_burst(input burst_t b);
		logic [20:0] cp;
		burst_t      r;
		r = b;
		unique case (b.cnt)
			3'd2:    cp = {10'd0, b.bytes[0][4:0], b.bytes[1][5:0]};
			3'd3:    cp = {5'd0, b.bytes[0][3:0], b.bytes[1][5:0], b.bytes[2][5:0]};
			default: cp = {b.bytes[0][2:0], b.bytes[1][5:0], b.bytes[2][5:0],
			               b.bytes[3][5:0]};
		endcase
		cp = fold_cp(cp);
		unique case (b.cnt)
			3'd2: begin
				r.bytes[0] = {3'b110, cp[10:6]};
				r.bytes[1] = {2'b10, cp[5:0]};
			end
			3'd3: begin
				r.bytes[0] = {4'b1110, cp[15:12]};
				r.bytes[1] = {2'b10, cp[11:6]};
				r.bytes[2] = {2'b10, cp[5:0]};
			end
			default: begin
				r.bytes[0] = {5'b11110, cp[20:18]};
				r.bytes[1] = {2'b10, cp[17:12]};
				r.bytes[2] = {2'b10, cp[11:6]};
				r.bytes[3] = {2'b10, cp[5:0]};
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/ucf_front.sv
// Front end: accepts bytes, tracks the pending sequence, builds result bursts.
// Depends on ucf_pkg.
`default_nettype none

module ucf_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [7:0]      in_byte,
	input  wire logic            end_of_text,
	input  wire logic            q_full,
	output logic                 in_stall,
	output logic                 push,
	output ucf_pkg::burst_t      burst
);
	import ucf_pkg::*;

	logic [2:0][7:0] held_q, held_d;
	logic [1:0]      hcnt_q, hcnt_d;
	logic [2:0]      exp_q, exp_d;
	logic [2:0]      n;
	logic            accept;
	logic            is_cont;
	logic            do_begin;
	logic [2:0]      blen;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign blen     = lead_len(in_byte);

	always_comb begin
		burst    = '0;
		n        = '0;
		held_d   = held_q;
		hcnt_d   = hcnt_q;
		exp_d    = exp_q;
		do_begin = 1'b0;

		if (hcnt_q == 2'd0) begin
			do_begin = 1'b1;
		end else if (is_cont) begin
			if (hcnt_q == 2'd1 && !second_ok(held_q[0], in_byte)) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < hcnt_q) begin
						burst.bytes[n[1:0]] = held_q[i];
						n = n + 3'd1;
					end
				end
				burst.bytes[n[1:0]] = in_byte;
				n = n + 3'd1;
				hcnt_d = '0;
				exp_d  = '0;
			end else if ({1'b0, hcnt_q} + 3'd1 == exp_q) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < hcnt_q) begin
						burst.bytes[n[1:0]] = held_q[i];
						n = n + 3'd1;
					end
				end
				burst.bytes[n[1:0]] = in_byte;
				n = n + 3'd1;
				burst.fold = 1'b1;
				hcnt_d = '0;
				exp_d  = '0;
			end else if (hcnt_q < 2'd3) begin
				held_d[hcnt_q] = in_byte;
				hcnt_d = hcnt_q + 2'd1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					burst.bytes[n[1:0]] = held_q[i];
					n = n + 3'd1;
				end
				burst.bytes[n[1:0]] = in_byte;
				n = n + 3'd1;
				hcnt_d = '0;
				exp_d  = '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < hcnt_q) begin
					burst.bytes[n[1:0]] = held_q[i];
					n = n + 3'd1;
				end
			end
			hcnt_d   = '0;
			exp_d    = '0;
			do_begin = 1'b1;
		end

		if (do_begin) begin
			if (!in_byte[7]) begin
				burst.bytes[n[1:0]] = (in_byte >= 8'h41 && in_byte <= 8'h5A) ?
				                      in_byte + 8'h20 : in_byte;
				n = n + 3'd1;
			end else if (blen == 3'd0) begin
				burst.bytes[n[1:0]] = in_byte;
				n = n + 3'd1;
			end else begin
				held_d[0] = in_byte;
				hcnt_d    = 2'd1;
				exp_d     = blen;
			end
		end

		// end of text: flush whatever is still pending
		if (end_of_text && hcnt_d != 2'd0) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < hcnt_d) begin
					burst.bytes[n[1:0]] = held_d[i];
					n = n + 3'd1;
				end
			end
			hcnt_d = '0;
			exp_d  = '0;
		end

		burst.cnt = n;
		burst.eot = end_of_text;
	end

	assign push = accept && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			exp_q  <= '0;
		end else if (accept) begin
			hcnt_q <= hcnt_d;
			exp_q  <= exp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			held_q <= held_d;
	end

endmodule

`default_nettype wire

// File: rtl/core/ucf_queue.sv
// Short FIFO of result bursts between front and back end.
// Depends on ucf_pkg.
`default_nettype none

module ucf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ucf_pkg::burst_t wdata,
	input  wire logic            pop,
	output logic                 full,
	output logic                 head_valid,
	output ucf_pkg::burst_t      head
);
	import ucf_pkg::*;

	burst_t            ent_q [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QCW-1:0]    cnt_q;

	assign full       = (cnt_q == QCW'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

// File: rtl/core/ucf_back.sv
// Back end: folds complete sequences; one byte per cycle out when not stalled.
// Depends on ucf_pkg.
`default_nettype none

module ucf_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire ucf_pkg::burst_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 text_done
);
	import ucf_pkg::*;

	burst_t     cur_q;
	logic [1:0] idx_q;
	logic       vld_q;
	logic       last;
	logic       taken;

	assign last      = ({1'b0, idx_q} + 3'd1 == cur_q.cnt);
	assign taken     = vld_q && !out_stall;
	assign pop       = head_valid && (!vld_q || (taken && last));
	assign out_valid = vld_q;
	assign out_byte  = cur_q.bytes[idx_q];
	assign run_last  = last;
	assign text_done = last && cur_q.eot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (taken && last) begin
			vld_q <= 1'b0;
		end else if (taken) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head.fold ? fold_burst(head) : head;
	end

endmodule

`default_nettype wire

// File: rtl/core/utf8_simple_case_fold_top.sv
// UTF-8 simple case fold, top level: front end, burst queue, back end.
// Depends on ucf_pkg, ucf_front, ucf_queue, ucf_back.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------
//  in      | in_valid / in_stall   | in_byte, end_of_text
//  out     | out_valid / out_stall | out_byte, run_last, text_done
//
// One input byte per cycle unless in_stall; one output byte per cycle unless
// out_stall, a byte's burst of 0..4. Bursts go through the queue and cur_q.
// Up to four bursts wait in the queue; in_stall rises only when it is full.
// Reset clears the pending sequence and empties the queue.
`default_nettype none

module utf8_simple_case_fold_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            text_done
);
	import ucf_pkg::*;

	burst_t wburst;
	burst_t head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   head_valid;

	ucf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.in_stall    (in_stall),
		.push        (push),
		.burst       (wburst)
	);

	ucf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (wburst),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	ucf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.text_done  (text_done)
	);

endmodule

`default_nettype wire

// File: rtl/core/ucf_monitor.sv
// Port-level assertions for the case fold top level, attached by bind.
// Depends on utf8_simple_case_fold_top.
`default_nettype none

module ucf_monitor (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] in_byte,
	input wire logic       end_of_text,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       run_last,
	input wire logic       text_done
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(end_of_text))
		else $error("input item changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
		$stable(run_last) && $stable(text_done))
		else $error("output item changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("text_done without run_last");

	a_no_upper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_byte >= 8'h41 && out_byte <= 8'h5A))
		else $error("upper-case ASCII left unfolded");

endmodule

bind utf8_simple_case_fold_top ucf_monitor u_monitor (.*);

`default_nettype wire
